### sv/pper_pkg.sv
`timescale 1ns / 1ps

package pper_pkg;

    localparam int CoordW    = 16;  // signed Q12.4 coordinate
    localparam int AbsW      = 16;  // magnitude of a coordinate difference
    localparam int SqW       = 32;  // square of a magnitude
    localparam int RadW      = 34;  // radicand, padded to an even bit count
    localparam int RootW     = 17;  // floor square root of the radicand
    localparam int RemW      = 18;  // partial remainder of the root
    localparam int SumW      = 25;  // unsigned Q21.4 perimeter
    localparam int StepCntW  = 5;
    localparam logic [StepCntW-1:0] RootSteps = StepCntW'(RadW / 2);
    localparam logic [SumW-1:0]     SumMax    = '1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // capture the accepted vertex
        logic open;       // start a polygon at the captured vertex
        logic sel_first;  // edge runs to the first vertex, not the previous one
        logic diff;       // form the absolute coordinate differences
        logic sq_x;       // square the x difference
        logic sq_y;       // square the y difference
        logic root_init;  // load the radicand into the root unit
        logic root_step;  // one digit of the root
        logic acc;        // add the edge length to the running sum
        logic emit;       // move the perimeter to the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic have_first;
        logic last;
        logic root_done;
        logic out_free;
    } t_stat;

endpackage

### sv/pper_if.sv
`timescale 1ns / 1ps

interface pper_in_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [pper_pkg::CoordW-1:0]    x_coord;
    logic signed [pper_pkg::CoordW-1:0]    y_coord;
    logic                                  last_vertex;

    modport source (output valid, output x_coord, output y_coord, output last_vertex,
                    input ready);
    modport sink   (input valid, input x_coord, input y_coord, input last_vertex,
                    output ready);
endinterface

interface pper_out_if;
    logic                            valid;
    logic                            ready;
    logic [pper_pkg::SumW-1:0]       perimeter_sum;
    logic                            saturated;

    modport source (output valid, output perimeter_sum, output saturated, input ready);
    modport sink   (input valid, input perimeter_sum, input saturated, output ready);
endinterface

### sv/polygon_perimeter_top.sv
// Channel  Dir  Payload                                   Handshake
// i_in     in   x_coord[15:0] s, y_coord[15:0] s, last    valid/ready
// o_out    out  perimeter_sum[24:0], saturated            valid/ready
//
// One vertex item is worked on at a time. The first vertex of a polygon is
// captured and opens the polygon; every later vertex runs its edge (capture,
// difference, two squares on one shared multiplier, root load, 17 root steps
// plus a state that sees them done, accumulate). After a marked later vertex
// the closing edge runs the same way; any marked vertex then emits the sum.
// Reset is synchronous and active low; it empties the polygon and the output.
// A stalled output holds its item; processing then waits before the next emit.
`timescale 1ns / 1ps

module polygon_perimeter_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    pper_in_if.sink      i_in,
    pper_out_if.source   o_out
);
    import pper_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    // The controller sequences the edge computations; it accepts a vertex
    // only while it is idle.
    pper_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // The datapath holds the polygon state, the root unit and the output
    // register, so a finished perimeter can wait while the next vertex enters.
    pper_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_x         (i_in.x_coord),
        .i_y         (i_in.y_coord),
        .i_last      (i_in.last_vertex),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_sum       (o_out.perimeter_sum),
        .o_sat       (o_out.saturated)
    );

endmodule

### sv/pper_dp.sv
`timescale 1ns / 1ps

module pper_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  pper_pkg::t_cmd                    i_cmd,
    output pper_pkg::t_stat                   o_stat,
    input  logic signed [pper_pkg::CoordW-1:0] i_x,
    input  logic signed [pper_pkg::CoordW-1:0] i_y,
    input  logic                              i_last,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic [pper_pkg::SumW-1:0]         o_sum,
    output logic                              o_sat
);
    import pper_pkg::*;

    logic signed [CoordW-1:0] r_cur_x, r_cur_y, r_first_x, r_first_y, r_prev_x, r_prev_y;
    logic                     r_last;
    logic                     r_have_first;
    logic [AbsW-1:0]          r_ax, r_ay;
    logic [SqW-1:0]           r_sqx, r_sqy;
    logic [RadW-1:0]          r_rad;
    logic [RemW-1:0]          r_rem;
    logic [RootW-1:0]         r_root;
    logic [StepCntW-1:0]      r_cnt;
    logic [SumW-1:0]          r_sum;
    logic                     r_clamped;
    logic                     r_out_valid;
    logic [SumW-1:0]          r_out_sum;
    logic                     r_out_sat;

    logic signed [CoordW-1:0] w_ref_x, w_ref_y;
    logic signed [CoordW:0]   w_dx, w_dy;
    logic [CoordW:0]          w_mx, w_my;
    logic [AbsW-1:0]          w_mul_op;
    logic [SqW-1:0]           w_prod;
    logic [SqW:0]             w_rad_sum;
    logic [RemW+1:0]          w_rem_sh, w_trial, w_rem_sub;
    logic [SumW:0]            w_acc;

    assign w_ref_x = i_cmd.sel_first ? r_first_x : r_prev_x;
    assign w_ref_y = i_cmd.sel_first ? r_first_y : r_prev_y;
    assign w_dx    = {r_cur_x[CoordW-1], r_cur_x} - {w_ref_x[CoordW-1], w_ref_x};
    assign w_dy    = {r_cur_y[CoordW-1], r_cur_y} - {w_ref_y[CoordW-1], w_ref_y};
    assign w_mx    = w_dx[CoordW] ? (CoordW+1)'(-w_dx) : w_dx;
    assign w_my    = w_dy[CoordW] ? (CoordW+1)'(-w_dy) : w_dy;

    // One multiplier, shared by the two squares.
    assign w_mul_op  = i_cmd.sq_y ? r_ay : r_ax;
    assign w_prod    = w_mul_op * w_mul_op;
    assign w_rad_sum = {1'b0, r_sqx} + {1'b0, r_sqy};

    // Restoring square root, two radicand bits per step.
    assign w_rem_sh  = {r_rem, r_rad[RadW-1 -: 2]};
    assign w_trial   = {1'b0, r_root, 2'b01};
    assign w_rem_sub = w_rem_sh - w_trial;

    assign w_acc = {1'b0, r_sum} + (SumW+1)'(r_root);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cur_x <= i_x;
            r_cur_y <= i_y;
            r_last  <= i_last;
        end
        if (i_cmd.open) begin
            r_first_x <= r_cur_x;
            r_first_y <= r_cur_y;
            r_prev_x  <= r_cur_x;
            r_prev_y  <= r_cur_y;
        end
        if (i_cmd.diff) begin
            r_ax <= w_mx[AbsW-1:0];
            r_ay <= w_my[AbsW-1:0];
        end
        if (i_cmd.sq_x) begin
            r_sqx <= w_prod;
        end
        if (i_cmd.sq_y) begin
            r_sqy <= w_prod;
        end
        if (i_cmd.root_init) begin
            r_rad  <= RadW'(w_rad_sum);
            r_rem  <= '0;
            r_root <= '0;
            r_cnt  <= '0;
        end else if (i_cmd.root_step) begin
            r_rad <= {r_rad[RadW-3:0], 2'b00};
            r_cnt <= r_cnt + 1'b1;
            if (w_rem_sh >= w_trial) begin
                r_rem  <= w_rem_sub[RemW-1:0];
                r_root <= {r_root[RootW-2:0], 1'b1};
            end else begin
                r_rem  <= w_rem_sh[RemW-1:0];
                r_root <= {r_root[RootW-2:0], 1'b0};
            end
        end
        if (i_cmd.acc && !i_cmd.sel_first) begin
            r_prev_x <= r_cur_x;
            r_prev_y <= r_cur_y;
        end
        if (i_cmd.emit) begin
            r_out_sum <= r_sum;
            r_out_sat <= r_clamped;
        end
    end

    // Running sum and its clamp flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum     <= '0;
            r_clamped <= 1'b0;
        end else if (i_cmd.open || i_cmd.emit) begin
            r_sum     <= '0;
            r_clamped <= 1'b0;
        end else if (i_cmd.acc) begin
            if (w_acc[SumW]) begin
                r_sum     <= SumMax;
                r_clamped <= 1'b1;
            end else begin
                r_sum <= w_acc[SumW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_first <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.open) begin
                r_have_first <= 1'b1;
            end else if (i_cmd.emit) begin
                r_have_first <= 1'b0;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.have_first = r_have_first;
    assign o_stat.last       = r_last;
    assign o_stat.root_done  = (r_cnt == RootSteps);
    assign o_stat.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_sum       = r_out_sum;
    assign o_sat       = r_out_sat;

endmodule

### sv/pper_ctrl.sv
`timescale 1ns / 1ps

module pper_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  pper_pkg::t_stat i_stat,
    output pper_pkg::t_cmd  o_cmd
);
    import pper_pkg::*;

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_OPEN      = 4'd1;
    localparam logic [3:0] S_DIFF      = 4'd2;
    localparam logic [3:0] S_SQX       = 4'd3;
    localparam logic [3:0] S_SQY       = 4'd4;
    localparam logic [3:0] S_ROOT_INIT = 4'd5;
    localparam logic [3:0] S_ROOT      = 4'd6;
    localparam logic [3:0] S_ACC       = 4'd7;
    localparam logic [3:0] S_EMIT      = 4'd8;

    logic [3:0] r_state, n_state;
    logic       r_close, n_close;   // working on the closing edge

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_close <= 1'b0;
        end else begin
            r_state <= n_state;
            r_close <= n_close;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_close       = r_close;
        o_cmd         = '0;
        o_cmd.sel_first = r_close;
        o_in_ready    = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_close    = 1'b0;
                    n_state    = i_stat.have_first ? S_DIFF : S_OPEN;
                end
            end
            S_OPEN: begin
                o_cmd.open = 1'b1;
                n_state    = i_stat.last ? S_EMIT : S_IDLE;
            end
            S_DIFF: begin
                o_cmd.diff = 1'b1;
                n_state    = S_SQX;
            end
            S_SQX: begin
                o_cmd.sq_x = 1'b1;
                n_state    = S_SQY;
            end
            S_SQY: begin
                o_cmd.sq_y = 1'b1;
                n_state    = S_ROOT_INIT;
            end
            S_ROOT_INIT: begin
                o_cmd.root_init = 1'b1;
                n_state         = S_ROOT;
            end
            S_ROOT: begin
                if (i_stat.root_done) begin
                    n_state = S_ACC;
                end else begin
                    o_cmd.root_step = 1'b1;
                end
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                if (i_stat.last && !r_close) begin
                    n_close = 1'b1;
                    n_state = S_DIFF;
                end else if (i_stat.last) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

### sv/pper_chk.sv
`timescale 1ns / 1ps

module pper_chk (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      i_in_ready,
    input logic                      i_out_valid,
    input logic                      i_out_ready,
    input logic [pper_pkg::SumW-1:0] i_sum,
    input logic                      i_sat
);
    import pper_pkg::*;

    // A result waiting on the sink stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output item dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_sum) && $stable(i_sat))
        else $error("output payload changed while stalled");

    // One vertex at a time: the block is not ready in the cycle after an accept.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("vertex accepted while the previous one is in work");

    // A clamped perimeter reads as the full-scale value.
    a_sat_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_sat |-> i_sum == SumMax)
        else $error("saturated result is not full scale");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

endmodule

bind polygon_perimeter_top pper_chk u_pper_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_sum       (o_out.perimeter_sum),
    .i_sat       (o_out.saturated)
);
